[design/mi3_pkg.sv]
// package: types, constants and tables for the 3x3 matrix inverse unit
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int unsigned ElemW   = 32;
  localparam int unsigned NumElem = 9;
  localparam int unsigned ProdW   = 64;
  localparam int unsigned DetW    = 98;
  localparam int unsigned QuotW   = 32;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned NumProd = 18;
  localparam int unsigned NumDet  = 3;
  localparam int unsigned NumStep = 32;

  localparam logic [IdxW-1:0]  FirstIdx = 4'd0;
  localparam logic [IdxW-1:0]  LastIdx  = 4'd8;
  localparam logic [QuotW-1:0] QuotMax  = 32'h7fff_ffff;
  localparam logic [QuotW-1:0] QuotMin  = 32'h8000_0000;

  // operand pairs of the cofactor products, two per cofactor (first minus second)
  localparam int unsigned MulA [NumProd] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam int unsigned MulB [NumProd] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};
  // cofactors used in the determinant expansion along column 0
  localparam int unsigned DetSel [NumDet] = '{0, 3, 6};

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [DetW-1:0]  det_t;

  typedef struct packed {
    logic signed [ElemW-1:0] a_r0c0;
    logic signed [ElemW-1:0] a_r1c0;
    logic signed [ElemW-1:0] a_r2c0;
    logic signed [ElemW-1:0] a_r0c1;
    logic signed [ElemW-1:0] a_r1c1;
    logic signed [ElemW-1:0] a_r2c1;
    logic signed [ElemW-1:0] a_r0c2;
    logic signed [ElemW-1:0] a_r1c2;
    logic signed [ElemW-1:0] a_r2c2;
  } in_t;

  typedef struct packed {
    logic signed [ElemW-1:0] inv_r0c0;
    logic signed [ElemW-1:0] inv_r1c0;
    logic signed [ElemW-1:0] inv_r2c0;
    logic signed [ElemW-1:0] inv_r0c1;
    logic signed [ElemW-1:0] inv_r1c1;
    logic signed [ElemW-1:0] inv_r2c1;
    logic signed [ElemW-1:0] inv_r0c2;
    logic signed [ElemW-1:0] inv_r1c2;
    logic signed [ElemW-1:0] inv_r2c2;
    logic                    singular;
    logic                    saturated;
  } out_t;

  // one quotient request into the divider
  typedef struct packed {
    logic [ProdW-1:0] amag;
    logic [DetW-1:0]  dmag;
    logic             neg;
    logic             sing;
    logic [IdxW-1:0]  idx;
  } div_req_t;

  // partial state of one division as it walks down the divider
  typedef struct packed {
    logic [DetW-1:0]  rem;
    logic [DetW-1:0]  dmag;
    logic [QuotW-1:0] quot;
    logic             presat;
    logic             neg;
    logic             sing;
    logic [IdxW-1:0]  idx;
  } div_state_t;

  // one finished, clamped quotient
  typedef struct packed {
    logic [QuotW-1:0] quot;
    logic             sat;
    logic             sing;
    logic [IdxW-1:0]  idx;
  } div_res_t;

endpackage

[design/mi3_front.sv]
// front end: cofactor products, cofactors and determinant over six stages
`timescale 1ns / 1ps
module mi3_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          in_valid_i,
  input  mi3_pkg::in_t  in_data_i,
  output logic          valid_o,
  output mi3_pkg::prod_t adj_o [mi3_pkg::NumElem],
  output mi3_pkg::det_t det_o
);

  logic [5:0] vld_q;

  mi3_pkg::elem_t m_q   [mi3_pkg::NumElem];
  mi3_pkg::elem_t mc2_q [mi3_pkg::NumDet];
  mi3_pkg::elem_t mc3_q [mi3_pkg::NumDet];
  mi3_pkg::prod_t pr_q  [mi3_pkg::NumProd];
  mi3_pkg::prod_t adj3_q [mi3_pkg::NumElem];
  mi3_pkg::prod_t adj4_q [mi3_pkg::NumElem];
  mi3_pkg::prod_t adj5_q [mi3_pkg::NumElem];
  mi3_pkg::prod_t adj6_q [mi3_pkg::NumElem];
  logic signed [mi3_pkg::ProdW-1:0] phi_q [mi3_pkg::NumDet];
  logic signed [mi3_pkg::ProdW:0]   plo_q [mi3_pkg::NumDet];
  mi3_pkg::det_t  row_q [mi3_pkg::NumDet];
  mi3_pkg::det_t  det_q;

  // valid bits move with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], in_valid_i};
    end
  end

  // stage 1: matrix register, column-major
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= in_data_i.a_r0c0;
      m_q[1] <= in_data_i.a_r1c0;
      m_q[2] <= in_data_i.a_r2c0;
      m_q[3] <= in_data_i.a_r0c1;
      m_q[4] <= in_data_i.a_r1c1;
      m_q[5] <= in_data_i.a_r2c1;
      m_q[6] <= in_data_i.a_r0c2;
      m_q[7] <= in_data_i.a_r1c2;
      m_q[8] <= in_data_i.a_r2c2;
    end
  end

  // stage 2: the eighteen 32x32 products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < mi3_pkg::NumProd; i++) begin
        pr_q[i] <= mi3_pkg::prod_t'(m_q[mi3_pkg::MulA[i]])
                 * mi3_pkg::prod_t'(m_q[mi3_pkg::MulB[i]]);
      end
      for (int j = 0; j < mi3_pkg::NumDet; j++) begin
        mc2_q[j] <= m_q[j];
      end
    end
  end

  // stage 3: signed cofactors, already transposed into adjugate order
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < mi3_pkg::NumElem; k++) begin
        adj3_q[k] <= pr_q[2*k] - pr_q[2*k+1];
      end
      for (int j = 0; j < mi3_pkg::NumDet; j++) begin
        mc3_q[j] <= mc2_q[j];
      end
    end
  end

  // stage 4: 32x64 determinant terms split into high and low halves
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < mi3_pkg::NumDet; j++) begin
        phi_q[j] <= (mi3_pkg::ProdW)'(mc3_q[j])
                  * (mi3_pkg::ProdW)'($signed(adj3_q[mi3_pkg::DetSel[j]][63:32]));
        plo_q[j] <= (mi3_pkg::ProdW+1)'(mc3_q[j])
                  * (mi3_pkg::ProdW+1)'($signed({1'b0, adj3_q[mi3_pkg::DetSel[j]][31:0]}));
      end
      adj4_q <= adj3_q;
    end
  end

  // stage 5: recombine each term
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < mi3_pkg::NumDet; j++) begin
        row_q[j] <= (mi3_pkg::det_t'(phi_q[j]) <<< 32) + mi3_pkg::det_t'(plo_q[j]);
      end
      adj5_q <= adj4_q;
    end
  end

  // stage 6: determinant
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q  <= row_q[0] + row_q[1] + row_q[2];
      adj6_q <= adj5_q;
    end
  end

  assign valid_o = vld_q[5];
  assign adj_o   = adj6_q;
  assign det_o   = det_q;

endmodule

[design/mi3_div_step.sv]
// one restoring division step with its stage register
`timescale 1ns / 1ps
module mi3_div_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  mi3_pkg::div_state_t st_i,
  output logic                valid_o,
  output mi3_pkg::div_state_t st_o
);

  logic                      valid_q;
  mi3_pkg::div_state_t       st_q;
  mi3_pkg::div_state_t       st_d;
  logic [mi3_pkg::DetW-1:0]  shifted;
  logic [mi3_pkg::DetW:0]    diff;
  logic                      ge;

  // shift in a zero numerator bit, subtract when it fits
  always_comb begin
    shifted = {st_i.rem[mi3_pkg::DetW-2:0], 1'b0};
    diff    = {1'b0, shifted} - {1'b0, st_i.dmag};
    ge      = ~diff[mi3_pkg::DetW];
    st_d      = st_i;
    st_d.rem  = ge ? diff[mi3_pkg::DetW-1:0] : shifted;
    st_d.quot = {st_i.quot[mi3_pkg::QuotW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;

endmodule

[design/mi3_divider.sv]
// pipelined divider: range check, 32 quotient steps, clamp and sign
`timescale 1ns / 1ps
module mi3_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  mi3_pkg::div_req_t req_i,
  output logic              valid_o,
  output mi3_pkg::div_res_t res_o
);

  logic                vld   [mi3_pkg::NumStep+1];
  mi3_pkg::div_state_t st    [mi3_pkg::NumStep+1];
  logic                vld0_q;
  mi3_pkg::div_state_t st0_q;
  logic [mi3_pkg::DetW-1:0] num_ext;
  logic                res_valid_q;
  mi3_pkg::div_res_t   res_q;
  mi3_pkg::div_res_t   res_d;
  mi3_pkg::div_state_t fin;

  // entry stage: quotient of 2^32 or more when the magnitude reaches the divisor
  assign num_ext = {{(mi3_pkg::DetW-mi3_pkg::ProdW){1'b0}}, req_i.amag};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en_i) begin
      vld0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st0_q.rem    <= num_ext;
      st0_q.dmag   <= req_i.dmag;
      st0_q.quot   <= '0;
      st0_q.presat <= (num_ext >= req_i.dmag);
      st0_q.neg    <= req_i.neg;
      st0_q.sing   <= req_i.sing;
      st0_q.idx    <= req_i.idx;
    end
  end

  assign vld[0] = vld0_q;
  assign st[0]  = st0_q;

  // one stage per quotient bit
  for (genvar g = 0; g < mi3_pkg::NumStep; g++) begin : g_step
    mi3_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (vld[g]),
      .st_i    (st[g]),
      .valid_o (vld[g+1]),
      .st_o    (st[g+1])
    );
  end

  // clamp to Q16.16 and apply the sign
  always_comb begin
    fin        = st[mi3_pkg::NumStep];
    res_d.sing = fin.sing;
    res_d.idx  = fin.idx;
    if (fin.presat) begin
      res_d.quot = fin.neg ? mi3_pkg::QuotMin : mi3_pkg::QuotMax;
      res_d.sat  = 1'b1;
    end else if (fin.neg) begin
      if (fin.quot > mi3_pkg::QuotMin) begin
        res_d.quot = mi3_pkg::QuotMin;
        res_d.sat  = 1'b1;
      end else begin
        res_d.quot = ~fin.quot + 1'b1;
        res_d.sat  = 1'b0;
      end
    end else begin
      if (fin.quot > mi3_pkg::QuotMax) begin
        res_d.quot = mi3_pkg::QuotMax;
        res_d.sat  = 1'b1;
      end else begin
        res_d.quot = fin.quot;
        res_d.sat  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (en_i) begin
      res_valid_q <= vld[mi3_pkg::NumStep];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = res_valid_q;
  assign res_o   = res_q;

endmodule

[design/matrix3x3_inverse_unit.sv]
// top level: 3x3 matrix inverse by adjugate over determinant, Q16.16
//
//  channel  valid        stall        payload       dir
//  input    in_valid_i   in_stall_o   in_data_i     in
//  output   out_valid_o  out_stall_i  out_data_o    out
//
// the nine quotients of a matrix share one divider, one issued per cycle unless out_stall_i freezes the pipeline
// out_valid_o rises once the matrix has passed the front stages, the hold register, the
// issue of its nine quotients, the divider and then the output register
// the next matrix moves into the hold register while the previous one's quotients drain
// out_stall_i freezes the whole pipeline while a waiting result sits in the output register
// reset clears valid bits and the issue counter only
`timescale 1ns / 1ps
module matrix3x3_inverse_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mi3_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mi3_pkg::out_t out_data_o
);

  logic                      en;
  logic                      front_adv;
  logic                      f_valid;
  mi3_pkg::prod_t            f_adj [mi3_pkg::NumElem];
  mi3_pkg::det_t             f_det;
  logic [mi3_pkg::DetW-1:0]  det_u;

  logic                      hold_valid_q;
  logic [mi3_pkg::IdxW-1:0]  cnt_q;
  logic [mi3_pkg::ProdW-1:0] amag_q [mi3_pkg::NumElem];
  logic [mi3_pkg::NumElem-1:0] aneg_q;
  logic [mi3_pkg::DetW-1:0]  dmag_q;
  logic                      sing_q;
  logic                      hold_last;
  mi3_pkg::div_req_t         req;

  logic                      d_valid;
  mi3_pkg::div_res_t         d_res;
  logic [mi3_pkg::QuotW-1:0] elem_q [mi3_pkg::NumElem-1];
  logic                      sat_acc_q;
  logic                      res_last;
  logic                      out_valid_q;
  mi3_pkg::out_t             out_q;
  mi3_pkg::out_t             out_d;

  // whole pipeline moves unless a finished result is held and out_stall_i is high
  assign en         = ~out_valid_q | ~out_stall_i;
  assign hold_last  = (cnt_q == mi3_pkg::LastIdx);
  assign front_adv  = en & (~hold_valid_q | hold_last);
  assign in_stall_o = ~front_adv;

  mi3_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (front_adv),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .valid_o    (f_valid),
    .adj_o      (f_adj),
    .det_o      (f_det)
  );

  // hold register control and issue counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      cnt_q        <= mi3_pkg::FirstIdx;
    end else begin
      if (front_adv) begin
        hold_valid_q <= f_valid;
      end
      if (en && hold_valid_q) begin
        cnt_q <= hold_last ? mi3_pkg::FirstIdx : cnt_q + 1'b1;
      end
    end
  end

  // magnitudes and quotient signs of the held matrix
  assign det_u = f_det;

  always_ff @(posedge clk_i) begin
    if (front_adv) begin
      dmag_q <= det_u[mi3_pkg::DetW-1] ? (~det_u + 1'b1) : det_u;
      sing_q <= (det_u == '0);
      for (int k = 0; k < mi3_pkg::NumElem; k++) begin
        amag_q[k] <= f_adj[k][mi3_pkg::ProdW-1] ? (~f_adj[k] + 1'b1) : f_adj[k];
        aneg_q[k] <= f_adj[k][mi3_pkg::ProdW-1] ^ det_u[mi3_pkg::DetW-1];
      end
    end
  end

  // one quotient request per cycle while a matrix is held and the pipeline is not frozen
  always_comb begin
    req.amag = amag_q[cnt_q];
    req.dmag = dmag_q;
    req.neg  = aneg_q[cnt_q];
    req.sing = sing_q;
    req.idx  = cnt_q;
  end

  mi3_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (hold_valid_q),
    .req_i   (req),
    .valid_o (d_valid),
    .res_o   (d_res)
  );

  // gather quotients; the last one completes the result
  assign res_last = (d_res.idx == mi3_pkg::LastIdx);

  always_ff @(posedge clk_i) begin
    if (en && d_valid && !res_last) begin
      elem_q[d_res.idx[mi3_pkg::IdxW-2:0]] <= d_res.quot;
      sat_acc_q <= ((d_res.idx == mi3_pkg::FirstIdx) ? 1'b0 : sat_acc_q) | d_res.sat;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_valid & res_last;
    end
  end

  // assemble the finished matrix; when singular the elements are zero and only the singular flag is set
  always_comb begin
    out_d = '0;
    if (d_res.sing) begin
      out_d.singular  = 1'b1;
    end else begin
      out_d.inv_r0c0  = elem_q[0];
      out_d.inv_r1c0  = elem_q[1];
      out_d.inv_r2c0  = elem_q[2];
      out_d.inv_r0c1  = elem_q[3];
      out_d.inv_r1c1  = elem_q[4];
      out_d.inv_r2c1  = elem_q[5];
      out_d.inv_r0c2  = elem_q[6];
      out_d.inv_r1c2  = elem_q[7];
      out_d.inv_r2c2  = d_res.quot;
      out_d.singular  = 1'b0;
      out_d.saturated = sat_acc_q | d_res.sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && d_valid && res_last) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
